FILE: hdl/stand_sit_posture_sequencer_core_defines.svh
// Assertion macros for the posture sequencer core
`ifndef STAND_SIT_POSTURE_SEQUENCER_CORE_DEFINES_SVH
`define STAND_SIT_POSTURE_SEQUENCER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssp assertion failed");
// next-cycle implication
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssp assertion failed");
`else
`define SSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/ssp_pkg.sv
// Shared types, constants and helper functions of the posture sequencer
package ssp_pkg;

    localparam int JOINT_COUNT_DEF = 12;
    localparam int ANGLE_BITS_DEF  = 16;

    localparam logic [15:0] TRANSITION_STEPS_RST = 16'd1000;
    localparam logic [15:0] HOLD_TICKS_RST       = 16'd2500;
    localparam logic [15:0] PASSIVE_TICKS_RST    = 16'd500;
    localparam logic [7:0]  INIT_SAMPLES_RST     = 8'd20;

    localparam logic [31:0] ANGLE_LIMIT  = 32'd10240;
    localparam logic [31:0] MOVE_MIN     = 32'd52;
    localparam logic [2:0]  PASSIVE_KD   = 3'd3;

    typedef enum logic [1:0] {
        CFG_TRANSITION = 2'd0,
        CFG_HOLD       = 2'd1,
        CFG_PASSIVE    = 2'd2,
        CFG_SAMPLES    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_STAND   = 3'd1,
        PH_HOLD    = 3'd2,
        PH_SIT     = 3'd3,
        PH_PASSIVE = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_SCAN, OP_ACCUM, OP_MUL, OP_DIVGO, OP_FIN, OP_CONST
    } t_op;

    typedef enum logic [2:0] {
        MODE_ZERO, MODE_HOLD, MODE_PASSIVE, MODE_AVG, MODE_STAND, MODE_SIT
    } t_mode;

    typedef struct packed {
        t_op         op;
        t_mode       mode;
        logic [3:0]  j;
        logic [1:0]  jt;
        logic [1:0]  leg;
        logic        last;
        logic        capture;
        t_phase      phase;
        logic [15:0] s;
        logic [15:0] den;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_ok;
        logic div_done;
        logic out_valid;
    } t_dp_stat;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) r = 16'sh7FFF;
        else if (v < -34'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] pose_of(input logic [1:0] jt,
                                                   input logic [1:0] leg,
                                                   input logic sit);
        logic signed [15:0] p;
        case (jt)
            2'd0:    p = sit ? (leg[0] ? -16'sd358 : 16'sd358) : 16'sd0;
            2'd1:    p = sit ? 16'sd1270 : 16'sd686;
            default: p = sit ? -16'sd2877 : -16'sd1331;
        endcase
        return p;
    endfunction

    function automatic logic [6:0] kp_of(input logic [1:0] jt);
        logic [6:0] k;
        case (jt)
            2'd0:    k = 7'd60;
            2'd1:    k = 7'd40;
            default: k = 7'd80;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] kd_of(input logic [1:0] jt);
        logic [2:0] k;
        case (jt)
            2'd0:    k = 3'd5;
            2'd1:    k = 3'd4;
            default: k = 3'd7;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/ssp_div.sv
// Restoring divider, one quotient bit per cycle, 32 by 16 bits unsigned
module ssp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [31:0] r_q;
    logic [16:0] w_trial;
    logic [16:0] w_diff;

    assign w_trial = {r_rem, r_q[31]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_diff[15:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_trial[15:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: hdl/ssp_datapath.sv
// Datapath: frame store, angle sums, start pose, multiplier, divider, output register
module ssp_datapath #(
    parameter int JOINT_COUNT = ssp_pkg::JOINT_COUNT_DEF,
    parameter int ANGLE_BITS  = ssp_pkg::ANGLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [191:0]           i_legs,
    input  ssp_pkg::t_dp_cmd       i_cmd,
    input  logic                   i_out_ready,
    output ssp_pkg::t_dp_stat      o_stat,
    output logic [3:0]             o_joint_index,
    output logic signed [15:0]     o_target,
    output logic [6:0]             o_kp,
    output logic [2:0]             o_kd,
    output logic [2:0]             o_phase,
    output logic                   o_last
);
    import ssp_pkg::*;

    localparam int JW       = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int SUM_BITS = ANGLE_BITS + 8;

    logic [47:0]                 r_leg [4];
    logic                        r_bad;
    logic                        r_big;
    logic signed [SUM_BITS-1:0]  r_sum [JOINT_COUNT];
    logic signed [15:0]          r_start [JOINT_COUNT];
    logic signed [32:0]          r_prod;
    logic                        r_neg;
    logic                        r_out_valid;
    logic [3:0]                  r_out_j;
    logic signed [15:0]          r_out_tgt;
    logic [6:0]                  r_out_kp;
    logic [2:0]                  r_out_kd;
    logic [2:0]                  r_out_ph;
    logic                        r_out_last;

    logic [JW-1:0]               w_idx;
    logic [47:0]                 w_word;
    logic signed [ANGLE_BITS-1:0] w_angle;
    logic signed [ANGLE_BITS:0]  w_angle_x;
    logic [ANGLE_BITS:0]         w_abs;
    logic [31:0]                 w_abs32;
    logic signed [17:0]          w_diff;
    logic signed [34:0]          w_prod;
    logic signed [32:0]          w_num_s;
    logic signed [32:0]          w_num_n;
    logic [31:0]                 w_mag;
    logic [31:0]                 w_divnum;
    logic                        w_div_done;
    logic [31:0]                 w_quot;
    logic signed [33:0]          w_q;
    logic signed [15:0]          w_avg;
    logic signed [15:0]          w_lerp;
    logic                        w_sit;

    function automatic logic signed [ANGLE_BITS-1:0] get_angle(input logic [47:0] word,
                                                               input logic [1:0] jt);
        logic [47:0] w;
        case (jt)
            2'd0:    w = word;
            2'd1:    w = word >> ANGLE_BITS;
            default: w = word >> (2 * ANGLE_BITS);
        endcase
        return w[ANGLE_BITS-1:0];
    endfunction

    assign w_idx     = i_cmd.j[JW-1:0];
    assign w_word    = r_leg[i_cmd.leg];
    assign w_angle   = get_angle(w_word, i_cmd.jt);
    assign w_angle_x = {w_angle[ANGLE_BITS-1], w_angle};
    assign w_abs     = w_angle_x[ANGLE_BITS] ? (ANGLE_BITS + 1)'(0) - w_angle_x : w_angle_x;
    assign w_abs32   = 32'(w_abs);

    assign w_sit  = (i_cmd.mode == MODE_SIT);
    assign w_diff = 18'(pose_of(i_cmd.jt, i_cmd.leg, w_sit)) - 18'(r_start[w_idx]);
    assign w_prod = w_diff * $signed({1'b0, i_cmd.s});

    // divider operand: magnitude plus half the divisor, sign kept aside
    assign w_num_s  = (i_cmd.mode == MODE_AVG) ? 33'(r_sum[w_idx]) : r_prod;
    assign w_num_n  = -w_num_s;
    assign w_mag    = w_num_s[32] ? w_num_n[31:0] : w_num_s[31:0];
    assign w_divnum = w_mag + {17'b0, i_cmd.den[15:1]};

    assign w_q    = r_neg ? -$signed({2'b0, w_quot}) : $signed({2'b0, w_quot});
    assign w_avg  = sat16(w_q);
    assign w_lerp = sat16(w_q + 34'(r_start[w_idx]));

    ssp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIVGO),
        .i_num   (w_divnum),
        .i_den   (i_cmd.den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            for (int k = 0; k < 4; k++) begin
                r_leg[k] <= i_legs[k*48 +: 48];
            end
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= w_prod[32:0];
        end
        if (i_cmd.op == OP_DIVGO) begin
            r_neg <= w_num_s[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad <= 1'b0;
            r_big <= 1'b0;
            for (int k = 0; k < JOINT_COUNT; k++) begin
                r_sum[k]   <= '0;
                r_start[k] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_bad <= 1'b0;
                    r_big <= 1'b0;
                end
                OP_SCAN: begin
                    if (w_abs32 > ANGLE_LIMIT) r_bad <= 1'b1;
                    if (w_abs32 >= MOVE_MIN)   r_big <= 1'b1;
                end
                OP_ACCUM: begin
                    r_sum[w_idx] <= r_sum[w_idx] + SUM_BITS'(w_angle);
                end
                OP_FIN: begin
                    if (i_cmd.mode == MODE_AVG) r_start[w_idx] <= w_avg;
                end
                OP_CONST: begin
                    if (i_cmd.capture) r_start[w_idx] <= sat16(34'(w_angle));
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FIN || i_cmd.op == OP_CONST) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN || i_cmd.op == OP_CONST) begin
            r_out_j    <= i_cmd.j;
            r_out_ph   <= i_cmd.phase;
            r_out_last <= i_cmd.last;
            if (i_cmd.op == OP_FIN) begin
                r_out_tgt <= (i_cmd.mode == MODE_AVG) ? w_avg : w_lerp;
                r_out_kp  <= kp_of(i_cmd.jt);
                r_out_kd  <= kd_of(i_cmd.jt);
            end else begin
                case (i_cmd.mode)
                    MODE_HOLD: begin
                        r_out_tgt <= pose_of(i_cmd.jt, i_cmd.leg, 1'b0);
                        r_out_kp  <= kp_of(i_cmd.jt);
                        r_out_kd  <= kd_of(i_cmd.jt);
                    end
                    MODE_PASSIVE: begin
                        r_out_tgt <= '0;
                        r_out_kp  <= '0;
                        r_out_kd  <= PASSIVE_KD;
                    end
                    default: begin
                        r_out_tgt <= '0;
                        r_out_kp  <= '0;
                        r_out_kd  <= '0;
                    end
                endcase
            end
        end
    end

    assign o_stat.frame_ok  = !r_bad && r_big;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_valid = r_out_valid;
    assign o_joint_index    = r_out_j;
    assign o_target         = r_out_tgt;
    assign o_kp             = r_out_kp;
    assign o_kd             = r_out_kd;
    assign o_phase          = r_out_ph;
    assign o_last           = r_out_last;
endmodule

FILE: hdl/ssp_ctrl.sv
// Controller: phase sequencing, tick counters, joint walk and datapath commands
module ssp_ctrl #(
    parameter int JOINT_COUNT = ssp_pkg::JOINT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_stamp,
    input  logic [15:0]        i_transition_steps,
    input  logic [15:0]        i_hold_ticks,
    input  logic [15:0]        i_passive_ticks,
    input  logic [7:0]         i_init_samples,
    input  logic               i_out_ready,
    input  ssp_pkg::t_dp_stat  i_stat,
    output ssp_pkg::t_dp_cmd   o_cmd
);
    import ssp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_ACCUM, S_MUL, S_DIVGO, S_DIVWAIT,
        S_FIN, S_CONST, S_OUT, S_END
    } t_state;

    t_state      r_state;
    t_phase      r_phase;
    t_phase      r_tick_ph;
    t_mode       r_mode;
    logic        r_capture;
    logic [15:0] r_step;
    logic [15:0] r_elapsed;
    logic [7:0]  r_count;
    logic [31:0] r_prev;
    logic [31:0] r_stamp;
    logic [3:0]  r_j;
    logic [1:0]  r_jt;
    logic [1:0]  r_leg;

    logic        w_accept;
    logic        w_out_acc;
    logic        w_last;
    logic [15:0] w_t_eff;
    logic [7:0]  w_need;
    logic [15:0] w_step_n;
    logic [15:0] w_elapsed_n;
    logic [7:0]  w_count_n;
    logic        w_dup;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_acc   = i_stat.out_valid && i_out_ready;
    assign w_last      = (r_j == 4'(JOINT_COUNT - 1));
    assign w_t_eff     = (i_transition_steps == 16'd0) ? 16'd1 : i_transition_steps;
    assign w_need      = (i_init_samples == 8'd0) ? 8'd1 : i_init_samples;
    assign w_step_n    = (r_step == 16'hFFFF) ? r_step : r_step + 16'd1;
    assign w_elapsed_n = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign w_count_n   = (r_count == 8'hFF) ? r_count : r_count + 8'd1;
    assign w_dup       = (r_stamp != 32'd0) && (r_stamp == r_prev);
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.mode    = r_mode;
        o_cmd.j       = r_j;
        o_cmd.jt      = r_jt;
        o_cmd.leg     = r_leg;
        o_cmd.last    = w_last;
        o_cmd.capture = r_capture;
        o_cmd.phase   = r_tick_ph;
        o_cmd.s       = (r_step < w_t_eff) ? r_step : w_t_eff;
        o_cmd.den     = (r_mode == MODE_AVG) ? {8'b0, r_count} : w_t_eff;
        unique case (r_state)
            S_IDLE:  o_cmd.op = w_accept ? OP_LOAD : OP_NONE;
            S_SCAN:  o_cmd.op = OP_SCAN;
            S_ACCUM: o_cmd.op = OP_ACCUM;
            S_MUL:   o_cmd.op = OP_MUL;
            S_DIVGO: o_cmd.op = OP_DIVGO;
            S_FIN:   o_cmd.op = OP_FIN;
            S_CONST: o_cmd.op = OP_CONST;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_INIT;
            r_tick_ph <= PH_INIT;
            r_mode    <= MODE_ZERO;
            r_capture <= 1'b0;
            r_step    <= '0;
            r_elapsed <= '0;
            r_count   <= '0;
            r_prev    <= '0;
            r_stamp   <= '0;
            r_j       <= '0;
            r_jt      <= '0;
            r_leg     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tick_ph <= r_phase;
                        r_stamp   <= i_stamp;
                        r_capture <= 1'b0;
                        r_j       <= '0;
                        r_jt      <= '0;
                        r_leg     <= '0;
                        unique case (r_phase)
                            PH_INIT: begin
                                r_state <= S_SCAN;
                            end
                            PH_STAND, PH_SIT: begin
                                r_step  <= w_step_n;
                                r_mode  <= (r_phase == PH_SIT) ? MODE_SIT : MODE_STAND;
                                r_state <= S_MUL;
                            end
                            PH_HOLD: begin
                                r_elapsed <= w_elapsed_n;
                                r_capture <= (w_elapsed_n >= i_hold_ticks);
                                r_mode    <= MODE_HOLD;
                                r_state   <= S_CONST;
                            end
                            PH_PASSIVE: begin
                                r_elapsed <= w_elapsed_n;
                                r_mode    <= MODE_PASSIVE;
                                r_state   <= S_CONST;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN, S_ACCUM: begin
                    if (w_last) begin
                        r_j   <= '0;
                        r_jt  <= '0;
                        r_leg <= '0;
                        if (r_state == S_SCAN) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_count <= w_count_n;
                            if (w_count_n >= w_need) begin
                                r_mode  <= MODE_AVG;
                                r_state <= S_DIVGO;
                            end else begin
                                r_mode  <= MODE_ZERO;
                                r_state <= S_CONST;
                            end
                        end
                    end else begin
                        r_j <= r_j + 4'd1;
                        if (r_jt == 2'd2) begin
                            r_jt  <= '0;
                            r_leg <= r_leg + 2'd1;
                        end else begin
                            r_jt <= r_jt + 2'd1;
                        end
                    end
                end
                S_DECIDE: begin
                    if (i_stat.frame_ok && r_stamp != 32'd0 && !w_dup) begin
                        r_prev <= r_stamp;
                    end
                    if (i_stat.frame_ok && !w_dup) begin
                        r_state <= S_ACCUM;
                    end else begin
                        r_mode  <= MODE_ZERO;
                        r_state <= S_CONST;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (i_stat.div_done) r_state <= S_FIN;
                end
                S_FIN, S_CONST: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        if (w_last) begin
                            r_state <= S_END;
                        end else begin
                            r_j <= r_j + 4'd1;
                            if (r_jt == 2'd2) begin
                                r_jt  <= '0;
                                r_leg <= r_leg + 2'd1;
                            end else begin
                                r_jt <= r_jt + 2'd1;
                            end
                            if (r_mode == MODE_STAND || r_mode == MODE_SIT) begin
                                r_state <= S_MUL;
                            end else if (r_mode == MODE_AVG) begin
                                r_state <= S_DIVGO;
                            end else begin
                                r_state <= S_CONST;
                            end
                        end
                    end
                end
                S_END: begin
                    r_state <= S_IDLE;
                    unique case (r_tick_ph)
                        PH_INIT: begin
                            if (r_mode == MODE_AVG) begin
                                r_phase <= PH_STAND;
                                r_step  <= '0;
                            end
                        end
                        PH_STAND, PH_SIT: begin
                            if (r_step >= w_t_eff) begin
                                r_phase   <= (r_tick_ph == PH_SIT) ? PH_PASSIVE : PH_HOLD;
                                r_elapsed <= '0;
                            end
                        end
                        PH_HOLD: begin
                            if (r_capture) begin
                                r_phase <= PH_SIT;
                                r_step  <= '0;
                            end
                        end
                        PH_PASSIVE: begin
                            if (r_elapsed >= i_passive_ticks) r_phase <= PH_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: hdl/stand_sit_posture_sequencer_core.sv
// Output: a tick answers with JOINT_COUNT beats, one joint at a time, each beat held until taken.
// Move ticks: per joint a multiply, a 32-step serial divide, then round and saturate, one joint
// at a time, each waiting for its beat to be taken; the shared serial divider sets the pace.
// Init ticks: a scan of every joint, plus a pass adding each joint to its sum when the frame is taken.
// Hold and passive ticks: a constant beat per joint, sent through the handshake. Done ticks: no beats.
// Reset: synchronous, active low; clears phase, counters, sums and start pose, reloads registers.
module stand_sit_posture_sequencer_core #(
    parameter int JOINT_COUNT = ssp_pkg::JOINT_COUNT_DEF,
    parameter int ANGLE_BITS  = ssp_pkg::ANGLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: frame_stamp[31:0], leg0_angles[79:32], leg1_angles[127:80],
    //        leg2_angles[175:128], leg3_angles[223:176]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,
    // tdata: joint_index[3:0], target_angle[19:4], stiffness[26:20], damping[29:27],
    //        phase_code[32:30], zero fill[39:33]; tlast: last_joint
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // register write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import ssp_pkg::*;

`include "stand_sit_posture_sequencer_core_defines.svh"

    logic [15:0]        r_transition_steps;
    logic [15:0]        r_hold_ticks;
    logic [15:0]        r_passive_ticks;
    logic [7:0]         r_init_samples;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [3:0]         w_jidx;
    logic signed [15:0] w_tgt;
    logic [6:0]         w_kp;
    logic [2:0]         w_kd;
    logic [2:0]         w_ph;

    // configuration registers; the user writes them only between ticks, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transition_steps <= TRANSITION_STEPS_RST;
            r_hold_ticks       <= HOLD_TICKS_RST;
            r_passive_ticks    <= PASSIVE_TICKS_RST;
            r_init_samples     <= INIT_SAMPLES_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRANSITION: r_transition_steps <= i_cfg_data;
                CFG_HOLD:       r_hold_ticks       <= i_cfg_data;
                CFG_PASSIVE:    r_passive_ticks    <= i_cfg_data;
                CFG_SAMPLES:    r_init_samples     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    ssp_ctrl #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (s_axis_tvalid),
        .o_in_ready         (s_axis_tready),
        .i_stamp            (s_axis_tdata[31:0]),
        .i_transition_steps (r_transition_steps),
        .i_hold_ticks       (r_hold_ticks),
        .i_passive_ticks    (r_passive_ticks),
        .i_init_samples     (r_init_samples),
        .i_out_ready        (m_axis_tready),
        .i_stat             (w_stat),
        .o_cmd              (w_cmd)
    );

    ssp_datapath #(
        .JOINT_COUNT (JOINT_COUNT),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_legs        (s_axis_tdata[223:32]),
        .i_cmd         (w_cmd),
        .i_out_ready   (m_axis_tready),
        .o_stat        (w_stat),
        .o_joint_index (w_jidx),
        .o_target      (w_tgt),
        .o_kp          (w_kp),
        .o_kd          (w_kd),
        .o_phase       (w_ph),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tvalid = w_stat.out_valid;
    assign m_axis_tdata  = {7'b0, w_ph, w_kd, w_kp, w_tgt, w_jidx};

    // a new frame is only taken once every beat of the previous tick has left
    `SSP_ASSERT_SAME(a_ready_when_drained, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    // the final beat of a tick is followed by an empty output register
    `SSP_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
    // a stalled beat stays valid and unchanged
    `SSP_ASSERT_NEXT(a_beat_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the stand/sit posture sequencer core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssp_pkg::*;

    // ---------------------------------------------------------------
    // Clock, reset and block ports
    // ---------------------------------------------------------------
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: frame_stamp, leg0_angles, leg1_angles, leg2_angles, leg3_angles
    logic [223:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: joint_index, target_angle, stiffness, damping, phase_code, zero fill
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    stand_sit_posture_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Expected joint commands, oldest first
    // ---------------------------------------------------------------
    typedef struct {
        logic [39:0] data;
        logic        last;
    } t_joint_cmd;

    t_joint_cmd cmd_queue[$];

    int mismatches   = 0;
    int ticks_sent   = 0;
    int beats_seen   = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 12;
    int rx_idle_pct  = 62;

    // ---------------------------------------------------------------
    // Sequencer shadow: registers and state
    // ---------------------------------------------------------------
    int unsigned move_ticks_cfg  = 1000;
    int unsigned hold_ticks_cfg  = 2500;
    int unsigned damp_ticks_cfg  = 500;
    int unsigned avg_frames_cfg  = 20;

    t_phase      seq_phase  = PH_INIT;
    int unsigned move_step  = 0;
    int unsigned dwell      = 0;
    int unsigned frames_avg = 0;
    logic [31:0] prev_stamp = '0;
    int          start_pose[12];
    longint      pose_sum[12];

    // fixed poses in Q5.10 and stance gains
    int stand_tgt[3] = '{0, 686, -1331};
    int sit_tgt[3]   = '{358, 1270, -2877};
    int stance_kp[3] = '{60, 40, 80};
    int stance_kd[3] = '{5, 4, 7};

    logic [31:0] last_stamp_sent = '0;

    function automatic int joint_meas(logic [223:0] frame, int j);
        logic signed [15:0] a;
        a = frame[32 + (j / 3) * 48 + (j % 3) * 16 +: 16];
        return int'(a);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint rounded_quot(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic int clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int target_pose(bit sitting, int j);
        if (!sitting) return stand_tgt[j % 3];
        if (j % 3 == 0) return ((j / 3) % 2 == 1) ? -358 : 358;
        return sit_tgt[j % 3];
    endfunction

    task automatic push_cmd(int j, int tgt, int kp, int kd, t_phase ph);
        t_joint_cmd c;
        logic [15:0] t16;
        t16 = tgt[15:0];
        c.data = {7'd0, ph, kd[2:0], kp[6:0], t16, j[3:0]};
        c.last = (j == 11);
        cmd_queue.push_back(c);
    endtask

    // Work out the commands of one accepted tick and advance the shadow.
    task automatic predict_tick(logic [223:0] frame);
        t_phase      ph;
        int unsigned need, lim, s;
        int          a, maxabs;
        bit          ok, sitting;
        logic [31:0] stamp;
        ph = seq_phase;
        stamp = frame[31:0];
        case (ph)
            PH_INIT: begin
                need = (avg_frames_cfg == 0) ? 1 : avg_frames_cfg;
                ok = 1;
                maxabs = 0;
                for (int j = 0; j < 12; j++) begin
                    a = joint_meas(frame, j);
                    if (a < 0) a = -a;
                    if (a > 10240) ok = 0;
                    if (a > maxabs) maxabs = a;
                end
                if (maxabs < 52) ok = 0;
                if (ok && stamp != 0) begin
                    if (stamp == prev_stamp) ok = 0;
                    else prev_stamp = stamp;
                end
                if (ok) begin
                    for (int j = 0; j < 12; j++) pose_sum[j] += joint_meas(frame, j);
                    if (frames_avg < 255) frames_avg++;
                end
                if (ok && frames_avg >= need) begin
                    for (int j = 0; j < 12; j++) begin
                        start_pose[j] = clip16(rounded_quot(pose_sum[j], frames_avg));
                        push_cmd(j, start_pose[j], stance_kp[j % 3], stance_kd[j % 3], ph);
                    end
                    move_step = 0;
                    seq_phase = PH_STAND;
                end else begin
                    for (int j = 0; j < 12; j++) push_cmd(j, 0, 0, 0, ph);
                end
            end
            PH_STAND, PH_SIT: begin
                sitting = (ph == PH_SIT);
                lim = (move_ticks_cfg == 0) ? 1 : move_ticks_cfg;
                if (move_step < 16'hFFFF) move_step++;
                s = (move_step < lim) ? move_step : lim;
                for (int j = 0; j < 12; j++) begin
                    push_cmd(j, clip16(start_pose[j] + rounded_quot(
                                 longint'(target_pose(sitting, j) - start_pose[j]) * s, lim)),
                             stance_kp[j % 3], stance_kd[j % 3], ph);
                end
                if (move_step >= lim) begin
                    dwell = 0;
                    seq_phase = sitting ? PH_PASSIVE : PH_HOLD;
                end
            end
            PH_HOLD: begin
                for (int j = 0; j < 12; j++)
                    push_cmd(j, target_pose(0, j), stance_kp[j % 3], stance_kd[j % 3], ph);
                if (dwell < 16'hFFFF) dwell++;
                if (dwell >= hold_ticks_cfg) begin
                    // measured angles of this tick seed the sit-down move
                    for (int j = 0; j < 12; j++) start_pose[j] = joint_meas(frame, j);
                    move_step = 0;
                    seq_phase = PH_SIT;
                end
            end
            PH_PASSIVE: begin
                for (int j = 0; j < 12; j++) push_cmd(j, 0, 0, 3, ph);
                if (dwell < 16'hFFFF) dwell++;
                if (dwell >= damp_ticks_cfg) seq_phase = PH_DONE;
            end
            default: ; // done: silent
        endcase
    endtask

    // ---------------------------------------------------------------
    // Mismatch reporting and result checking
    // ---------------------------------------------------------------
    task automatic report(string what, longint exp_v, longint got_v);
        $display("MISMATCH beat %0d: %s expected %0d got %0d", beats_seen, what, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_joint_cmd e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cmd_queue.size() == 0) begin
                report("unexpected beat, joint", 0, m_axis_tdata[3:0]);
            end else begin
                e = cmd_queue.pop_front();
                if (e.data[3:0] != m_axis_tdata[3:0])
                    report("joint_index", e.data[3:0], m_axis_tdata[3:0]);
                if (e.data[19:4] != m_axis_tdata[19:4])
                    report("target_angle", $signed(e.data[19:4]), $signed(m_axis_tdata[19:4]));
                if (e.data[26:20] != m_axis_tdata[26:20])
                    report("stiffness", e.data[26:20], m_axis_tdata[26:20]);
                if (e.data[29:27] != m_axis_tdata[29:27])
                    report("damping", e.data[29:27], m_axis_tdata[29:27]);
                if (e.data[32:30] != m_axis_tdata[32:30])
                    report("phase_code", e.data[32:30], m_axis_tdata[32:30]);
                if (m_axis_tdata[39:33] != 7'd0)
                    report("zero fill", 0, m_axis_tdata[39:33]);
                if (e.last != m_axis_tlast)
                    report("last_joint", e.last, m_axis_tlast);
            end
            beats_seen++;
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 1000000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // One tick; tvalid is left high so back-to-back ticks need no toggle.
    task automatic send_tick(logic [223:0] frame);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        last_stamp_sent = frame[31:0];
        predict_tick(frame);
        ticks_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic drain(int settle);
        s_axis_tvalid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[15:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TRANSITION: move_ticks_cfg = value & 16'hFFFF;
            CFG_HOLD:       hold_ticks_cfg = value & 16'hFFFF;
            CFG_PASSIVE:    damp_ticks_cfg = value & 16'hFFFF;
            default:        avg_frames_cfg = value & 8'hFF;
        endcase
    endtask

    function automatic logic [223:0] uniform_frame(logic [15:0] val, logic [31:0] stamp);
        logic [223:0] f;
        f[31:0] = stamp;
        for (int j = 0; j < 12; j++) f[32 + (j / 3) * 48 + (j % 3) * 16 +: 16] = val;
        return f;
    endfunction

    // Angles within +-10 rad; stamps mix zero, repeats and fresh values.
    function automatic logic [223:0] sane_frame();
        logic [223:0] f;
        int a;
        f = '0;
        case ($urandom_range(3))
            0:       f[31:0] = 32'd0;
            1:       f[31:0] = last_stamp_sent;
            default: f[31:0] = $urandom;
        endcase
        for (int j = 0; j < 12; j++) begin
            a = $urandom_range(20480) - 10240;
            f[32 + (j / 3) * 48 + (j % 3) * 16 +: 16] = a[15:0];
        end
        return f;
    endfunction

    function automatic logic [223:0] noise_frame();
        logic [223:0] f;
        for (int w = 0; w < 7; w++) f[w * 32 +: 32] = $urandom;
        return f;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_register_extremes();
        write_reg(CFG_TRANSITION, 65535);
        write_reg(CFG_HOLD, 65535);
        write_reg(CFG_PASSIVE, 65535);
        write_reg(CFG_SAMPLES, 255);
        write_reg(CFG_HOLD, 0);
        write_reg(CFG_PASSIVE, 1);
    endtask

    task automatic test_init_screening();
        logic [223:0] f;
        send_tick(uniform_frame(16'd0, 32'd0));            // all still: rejected
        send_tick(uniform_frame(16'd51, 32'd1));           // all within 0.05 rad
        send_tick(uniform_frame(-16'sd51, 32'd2));
        f = uniform_frame(16'd0, 32'd0);
        f[32 +: 16] = 16'd52;                              // smallest real motion
        send_tick(f);
        send_tick(uniform_frame(16'd10240, 32'hFFFF_FFFF)); // at the magnitude limit
        send_tick(uniform_frame(16'd10240, 32'hFFFF_FFFF)); // same stamp: dropped
        send_tick(uniform_frame(-16'sd10240, 32'd0));      // no stamp, no filtering
        send_tick(uniform_frame(-16'sd10240, 32'd0));
        f = uniform_frame(16'd300, 32'd5);
        f[223 -: 16] = 16'd10241;                          // one joint past the limit
        send_tick(f);
        send_tick(uniform_frame(16'h8000, 32'd6));         // most negative angle
        send_tick(uniform_frame(16'h7FFF, 32'd7));
        send_tick(uniform_frame(16'd700, 32'd6));          // old stamp, new frame
        drain(4);
    endtask

    task automatic test_init_averaging();
        tx_idle_pct = 12;
        rx_idle_pct = 62;
        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(99) < 70) send_tick(sane_frame());
            else send_tick(noise_frame());
        end
        drain(4);
        // averaging target already met: the next accepted frame closes INIT
        write_reg(CFG_SAMPLES, 0);
        while (seq_phase == PH_INIT) send_tick(sane_frame());
        drain(4);
    endtask

    task automatic test_stand_and_hold();
        tx_idle_pct = 62;
        rx_idle_pct = 12;
        write_reg(CFG_TRANSITION, 20);
        write_reg(CFG_HOLD, 6);
        for (int i = 0; i < 8; i++) send_tick(noise_frame());
        drain(4);
        // shorter move than steps already taken: position clamps to the pose
        write_reg(CFG_TRANSITION, 5);
        while (seq_phase == PH_STAND) send_tick(noise_frame());
        for (int i = 0; i < 3; i++) send_tick(noise_frame());
        drain(4);
        write_reg(CFG_HOLD, 0);
        send_tick(noise_frame());                          // hold ends here
        drain(4);
    endtask

    task automatic test_sit_down();
        write_reg(CFG_TRANSITION, 50);
        for (int i = 0; i < 20; i++) send_tick(noise_frame());
        drain(0);                                          // sender holds off
        for (int i = 0; i < 20; i++) send_tick(noise_frame());
        drain(4);
        write_reg(CFG_TRANSITION, 0);                      // acts as one step
        send_tick(noise_frame());
        drain(4);
    endtask

    task automatic test_passive_and_done();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_PASSIVE, 8);
        while (seq_phase == PH_PASSIVE) send_tick(noise_frame());
        for (int i = 0; i < 5; i++) send_tick(noise_frame()); // done: no beats
        drain(600);
    endtask

    initial begin
        for (int j = 0; j < 12; j++) begin
            start_pose[j] = 0;
            pose_sum[j] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_extremes();
        test_init_screening();
        test_init_averaging();
        test_stand_and_hold();
        test_sit_down();
        test_passive_and_done();

        if (cmd_queue.size() != 0)
            report("commands never delivered", cmd_queue.size(), 0);
        $display("Covered %0d ticks through init, stand-up, hold, sit-down, passive and done",
                 ticks_sent);
        $display("Checked %0d command beats over %0d cycles", beats_seen, cycle_count);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
